// File: src/block_sum_downsample_2d_macros.svh
// assertion macros for the block sum downsampler checker
// no dependencies; included by the checker file only
`ifndef BLOCK_SUM_DOWNSAMPLE_2D_MACROS_SVH
`define BLOCK_SUM_DOWNSAMPLE_2D_MACROS_SVH

// property checked while out of reset
`define BSD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every edge, reset included
`define BSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/bsd_pkg.sv
// shared types and constants for the block sum downsampler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bsd_pkg;

    localparam int GRAD_W      = 32;
    localparam int SUM_W       = 38;
    localparam int OUT_COL_W   = 10;
    localparam int SCALE_CFG_W = 4;
    localparam int WIDTH_CFG_W = 11;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 1'd1;

    // one finished block row heading into the column fold
    typedef struct packed {
        logic signed [SUM_W-1:0] hsum;
        logic                    first;
        logic                    last;
    } row_done_t;

endpackage

// File: src/bsd_front.sv
// position counters and horizontal row sum of the block sum downsampler
// depends on bsd_pkg
`timescale 1ns / 1ps

module bsd_front #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_SCALE     = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept_i,
    input  logic signed [bsd_pkg::GRAD_W-1:0]  grad_i,
    input  logic                               frame_start_i,
    input  logic [$clog2(MAX_SCALE+1)-1:0]     eff_scale_i,
    input  logic [$clog2(MAX_OUT_WIDTH+1)-1:0] eff_width_i,
    output logic                               done_o,
    output bsd_pkg::row_done_t                 row_o,
    output logic [$clog2(MAX_OUT_WIDTH)-1:0]   col_o
);

    localparam int SUB_W = $clog2(MAX_SCALE);
    localparam int SC_W  = $clog2(MAX_SCALE + 1);
    localparam int BC_W  = $clog2(MAX_OUT_WIDTH);
    localparam int W_W   = $clog2(MAX_OUT_WIDTH + 1);

    logic [SUB_W-1:0]                  sub_col_reg, sub_col_next;
    logic [SUB_W-1:0]                  sub_row_reg, sub_row_next;
    logic [BC_W-1:0]                   blk_col_reg, blk_col_next;
    logic signed [bsd_pkg::SUM_W-1:0]  hsum_reg, hsum_next;

    logic [SUB_W-1:0]                  sc, sr;
    logic [BC_W-1:0]                   bc;
    logic signed [bsd_pkg::SUM_W-1:0]  hs, hsum_new;
    logic                              row_end, band_end, line_end;

    always_comb begin
        // frame start restarts the position before this element counts
        sc = frame_start_i ? '0 : sub_col_reg;
        sr = frame_start_i ? '0 : sub_row_reg;
        bc = frame_start_i ? '0 : blk_col_reg;
        hs = frame_start_i ? '0 : hsum_reg;
        hsum_new = hs + bsd_pkg::SUM_W'(grad_i);
        row_end  = (SC_W'(sc) + SC_W'(1)) >= eff_scale_i;
        band_end = (SC_W'(sr) + SC_W'(1)) >= eff_scale_i;
        line_end = (W_W'(bc) + W_W'(1)) >= eff_width_i;

        sub_col_next = sub_col_reg;
        sub_row_next = sub_row_reg;
        blk_col_next = blk_col_reg;
        hsum_next    = hsum_reg;
        if (accept_i) begin
            sub_row_next = sr;
            blk_col_next = bc;
            if (!row_end) begin
                hsum_next    = hsum_new;
                sub_col_next = sc + SUB_W'(1);
            end else begin
                hsum_next    = '0;
                sub_col_next = '0;
                if (line_end) begin
                    blk_col_next = '0;
                    sub_row_next = band_end ? '0 : sr + SUB_W'(1);
                end else begin
                    blk_col_next = bc + BC_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_col_reg <= '0;
            sub_row_reg <= '0;
            blk_col_reg <= '0;
            hsum_reg    <= '0;
        end else begin
            sub_col_reg <= sub_col_next;
            sub_row_reg <= sub_row_next;
            blk_col_reg <= blk_col_next;
            hsum_reg    <= hsum_next;
        end
    end

    assign done_o      = accept_i && row_end;
    assign row_o.hsum  = hsum_new;
    assign row_o.first = (sr == '0);
    assign row_o.last  = band_end;
    assign col_o       = bc;

endmodule

// File: src/bsd_colmem.sv
// column partial sum memory with registered read and same-edge write bypass
// depends on bsd_pkg
`timescale 1ns / 1ps

module bsd_colmem #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              rd_en_i,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  rd_addr_i,
    output logic signed [bsd_pkg::SUM_W-1:0]  rd_data_o,
    input  logic                              wr_en_i,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0]  wr_addr_i,
    input  logic signed [bsd_pkg::SUM_W-1:0]  wr_data_i
);

    logic signed [bsd_pkg::SUM_W-1:0] mem_reg [MAX_OUT_WIDTH];
    logic signed [bsd_pkg::SUM_W-1:0] rd_q_reg;
    logic signed [bsd_pkg::SUM_W-1:0] byp_data_reg;
    logic                             byp_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en_i) begin
            mem_reg[wr_addr_i] <= wr_data_i;
        end
        if (rd_en_i) begin
            rd_q_reg     <= mem_reg[rd_addr_i];
            byp_data_reg <= wr_data_i;
        end
    end

    // a write to the read column on the read edge is not yet in rd_q
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
        end else if (rd_en_i) begin
            byp_valid_reg <= wr_en_i && (wr_addr_i == rd_addr_i);
        end
    end

    assign rd_data_o = byp_valid_reg ? byp_data_reg : rd_q_reg;

endmodule

// File: src/bsd_fold.sv
// fold stage: adds a finished row to its column sum, writes back or emits
// depends on bsd_pkg
`timescale 1ns / 1ps

module bsd_fold #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  load_i,
    input  bsd_pkg::row_done_t                    row_i,
    input  logic [$clog2(MAX_OUT_WIDTH)-1:0]      col_i,
    input  logic signed [bsd_pkg::SUM_W-1:0]      rd_data_i,
    output logic                                  free_o,
    output logic                                  wr_en_o,
    output logic [$clog2(MAX_OUT_WIDTH)-1:0]      wr_addr_o,
    output logic signed [bsd_pkg::SUM_W-1:0]      wr_data_o,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bsd_pkg::SUM_W-1:0]      m_block_sum,
    output logic [bsd_pkg::OUT_COL_W-1:0]         m_out_column
);

    localparam int BC_W = $clog2(MAX_OUT_WIDTH);

    logic                              st_valid_reg;
    bsd_pkg::row_done_t                st_row_reg;
    logic [BC_W-1:0]                   st_col_reg;
    logic                              out_valid_reg;
    logic signed [bsd_pkg::SUM_W-1:0]  out_sum_reg;
    logic [bsd_pkg::OUT_COL_W-1:0]     out_col_reg;

    logic signed [bsd_pkg::SUM_W-1:0]  band;
    logic                              advance;

    always_comb begin
        band    = (st_row_reg.first ? '0 : rd_data_i) + st_row_reg.hsum;
        advance = st_valid_reg && (!st_row_reg.last || !out_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_i) begin
                st_valid_reg <= 1'b1;
            end else if (advance) begin
                st_valid_reg <= 1'b0;
            end
            if (advance && st_row_reg.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            st_row_reg <= row_i;
            st_col_reg <= col_i;
        end
        if (advance && st_row_reg.last) begin
            out_sum_reg <= band;
            out_col_reg <= bsd_pkg::OUT_COL_W'(st_col_reg);
        end
    end

    assign free_o       = !st_valid_reg || advance;
    assign wr_en_o      = advance && !st_row_reg.last;
    assign wr_addr_o    = st_col_reg;
    assign wr_data_o    = band;
    assign m_valid      = out_valid_reg;
    assign m_block_sum  = out_sum_reg;
    assign m_out_column = out_col_reg;

endmodule

// File: src/block_sum_downsample_2d.sv
// top level of the block sum downsampler (nearest upsample 2d backward)
// depends on bsd_pkg, bsd_front, bsd_colmem, bsd_fold
//
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------
//  input    | s_valid / s_ready  | s_grad_value, s_frame_start
//  result   | m_valid / m_ready  | m_block_sum, m_out_column
//  config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// one element per cycle while s_ready is high; a block result is formed
// from the transfer of its bottom-right element through the registered
// column memory read and fold stage, then the fold add and output register.
// reset clears counters and handshake state; the column memory needs no
// clearing since each entry is written by the first row of a band.
// s_ready drops during reset and while a finished sum waits in both fold and output.
`timescale 1ns / 1ps

module block_sum_downsample_2d #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_SCALE     = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [bsd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [bsd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [bsd_pkg::GRAD_W-1:0]     s_grad_value,
    input  logic                                  s_frame_start,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bsd_pkg::SUM_W-1:0]      m_block_sum,
    output logic [bsd_pkg::OUT_COL_W-1:0]         m_out_column
);

    localparam int SC_W = $clog2(MAX_SCALE + 1);
    localparam int BC_W = $clog2(MAX_OUT_WIDTH);
    localparam int W_W  = $clog2(MAX_OUT_WIDTH + 1);

    logic [bsd_pkg::SCALE_CFG_W-1:0]  scale_reg;
    logic [bsd_pkg::WIDTH_CFG_W-1:0]  out_width_reg;
    logic [SC_W-1:0]                  eff_scale;
    logic [W_W-1:0]                   eff_width;

    logic                             accept;
    logic                             row_done;
    bsd_pkg::row_done_t               row;
    logic [BC_W-1:0]                  row_col;
    logic                             fold_free;
    logic signed [bsd_pkg::SUM_W-1:0] rd_data;
    logic                             wr_en;
    logic [BC_W-1:0]                  wr_addr;
    logic signed [bsd_pkg::SUM_W-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= bsd_pkg::SCALE_CFG_W'(2);
            out_width_reg <= bsd_pkg::WIDTH_CFG_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bsd_pkg::REG_SCALE:
                    scale_reg <= bsd_pkg::SCALE_CFG_W'(cfg_wdata);
                bsd_pkg::REG_OUT_WIDTH:
                    out_width_reg <= bsd_pkg::WIDTH_CFG_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // out-of-range settings saturate to the supported range
    always_comb begin
        if (scale_reg < bsd_pkg::SCALE_CFG_W'(2)) begin
            eff_scale = SC_W'(2);
        end else if (32'(scale_reg) > 32'(MAX_SCALE)) begin
            eff_scale = SC_W'(MAX_SCALE);
        end else begin
            eff_scale = SC_W'(scale_reg);
        end
        if (out_width_reg == '0) begin
            eff_width = W_W'(1);
        end else if (32'(out_width_reg) > 32'(MAX_OUT_WIDTH)) begin
            eff_width = W_W'(MAX_OUT_WIDTH);
        end else begin
            eff_width = W_W'(out_width_reg);
        end
    end

    assign s_ready = aresetn && fold_free;
    assign accept  = s_valid && s_ready;

    bsd_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_SCALE     (MAX_SCALE)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept_i      (accept),
        .grad_i        (s_grad_value),
        .frame_start_i (s_frame_start),
        .eff_scale_i   (eff_scale),
        .eff_width_i   (eff_width),
        .done_o        (row_done),
        .row_o         (row),
        .col_o         (row_col)
    );

    bsd_colmem #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_colmem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en_i   (row_done),
        .rd_addr_i (row_col),
        .rd_data_o (rd_data),
        .wr_en_i   (wr_en),
        .wr_addr_i (wr_addr),
        .wr_data_i (wr_data)
    );

    bsd_fold #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_fold (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_i       (row_done),
        .row_i        (row),
        .col_i        (row_col),
        .rd_data_i    (rd_data),
        .free_o       (fold_free),
        .wr_en_o      (wr_en),
        .wr_addr_o    (wr_addr),
        .wr_data_o    (wr_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_block_sum  (m_block_sum),
        .m_out_column (m_out_column)
    );

endmodule

// File: src/bsd_checker.sv
// port-level checker for the block sum downsampler, bound to the top level
// depends on block_sum_downsample_2d_macros.svh and bsd_pkg
`timescale 1ns / 1ps
`include "block_sum_downsample_2d_macros.svh"

module bsd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [bsd_pkg::SUM_W-1:0]  m_block_sum,
    input logic [bsd_pkg::OUT_COL_W-1:0]     m_out_column
);

    // a stalled result holds
    property p_out_hold;
        m_valid && !m_ready |=> m_valid && $stable(m_block_sum) && $stable(m_out_column);
    endproperty

    // input backpressure only while a result is stuck at the output
    property p_stall_cause;
        !s_ready |-> m_valid && !m_ready;
    endproperty

    // a fresh result follows an earlier input transfer
    property p_result_origin;
        $rose(m_valid) |-> $past(s_valid && s_ready, 2);
    endproperty

    // reset empties the output
    property p_reset_empty;
        !aresetn |=> !m_valid;
    endproperty

    `BSD_ASSERT(a_out_hold, aclk, aresetn, p_out_hold, "stalled result changed")
    `BSD_ASSERT(a_stall_cause, aclk, aresetn, p_stall_cause, "input stalled with free output")
    `BSD_ASSERT(a_result_origin, aclk, aresetn, p_result_origin, "result without transfer")
    `BSD_ASSERT_ALWAYS(a_reset_empty, aclk, p_reset_empty, "result valid after reset")

endmodule

bind block_sum_downsample_2d bsd_checker u_bsd_checker (.*);
